### src/tlop_pkg.sv
// shared types, constants and the 5x7 font for the text line to page frame block
`default_nettype none
package tlop_pkg;

   // line geometry
   localparam int LINE_CHARS  = 21;
   localparam int LINE_COUNT  = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] GLYPH_LIMIT = 8'd123;
   localparam logic [7:0] LAST_COL    = 8'd127;
   localparam logic [7:0] GLYPH_STEP  = 8'd6;

   // frame byte codes
   localparam logic [7:0] CMD_CTRL    = 8'h00;
   localparam logic [4:0] CMD_PAGE_HI = 5'b10110;
   localparam logic [7:0] CMD_COL_HI  = 8'h10;
   localparam logic [7:0] DATA_CTRL   = 8'h40;
   localparam logic [7:0] OFFSET_ALT  = 8'h02;
   localparam logic [7:0] OFFSET_STD  = 8'h00;

   // one work item for the back end
   typedef struct packed {
      logic        open;
      logic [2:0]  page;
      logic        ctype;
      logic        glyph;
      logic [39:0] glyph_cols;
      logic        pad;
      logic [7:0]  pad_start;
   } tlop_desc_type;

   // a descriptor with its valid flag, used for push and queue head
   typedef struct packed {
      logic          valid;
      tlop_desc_type desc;
   } tlop_slot_type;

   // font, first column in the top byte
   localparam logic [39:0] DIGIT_FONT [10] = '{
      40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
      40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
      40'h36_49_49_49_36, 40'h06_49_49_29_1E
   };

   localparam logic [39:0] LETTER_FONT [26] = '{
      40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22, 40'h7F_41_41_22_1C,
      40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F,
      40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
      40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E, 40'h7F_09_09_09_06,
      40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7F_01_01,
      40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
      40'h07_08_70_08_07, 40'h61_51_49_45_43
   };

   localparam logic [39:0] COLON_GLYPH = 40'h00_36_36_00_00;
   localparam logic [39:0] DOT_GLYPH   = 40'h00_60_60_00_00;
   localparam logic [39:0] SLASH_GLYPH = 40'h20_10_08_04_02;
   localparam logic [39:0] DASH_GLYPH  = 40'h08_08_08_08_08;
   localparam logic [39:0] UNDER_GLYPH = 40'h40_40_40_40_40;
   localparam logic [39:0] BLANK_GLYPH = 40'h00_00_00_00_00;
   localparam logic [39:0] BOX_GLYPH   = 40'h3E_22_22_22_3E;

   // glyph columns for a character code
   function automatic logic [39:0] glyph_of(input logic [7:0] code);
      logic [7:0]  c;
      logic [39:0] g;
      c = (code == 8'h00) ? 8'h20 : code;
      if (c >= 8'h61 && c <= 8'h7A) begin
         c = c - 8'h20;
      end
      if (c >= 8'h30 && c <= 8'h39) begin
         g = DIGIT_FONT[4'(c - 8'h30)];
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         g = LETTER_FONT[5'(c - 8'h41)];
      end else begin
         unique case (c)
            8'h3A:   g = COLON_GLYPH;
            8'h2E:   g = DOT_GLYPH;
            8'h2F:   g = SLASH_GLYPH;
            8'h2D:   g = DASH_GLYPH;
            8'h5F:   g = UNDER_GLYPH;
            8'h20:   g = BLANK_GLYPH;
            default: g = BOX_GLYPH;
         endcase
      end
      return g;
   endfunction

endpackage
`default_nettype wire

### src/text_line_to_oled_page_frames.sv
// top level: text characters in, display write payload bytes out
//
// req_ channel: one character per transfer (valid/stall). rsp_ channel: one
// payload byte per transfer with frame_first, frame_end and run_last flags.
// csr_ channel: write of controller_type (bit 0), always ready; write it only
// while the block is idle.
// A character yields 6 bytes (5 glyph columns and a spacer), 7 more on the
// first character of a line (page and column commands, data control byte),
// the zero padding through column 127 on the last one, and nothing for a
// character that falls past column 123 in mid-line.
// The first byte of a character passes through the descriptor queue and
// then the output register. Throughput: one byte per cycle from the back-end
// sequencer while rsp_ is not stalled; the front end runs ahead through a
// two-entry descriptor queue and stalls req_ only when that queue is full.
// A stall on rsp_ holds the output register; the sequencer and queue wait.
// Reset (synchronous) returns to page 0, column 0, first character of a
// line, controller type 0, and empties the queue and the output register.
`default_nettype none
module text_line_to_oled_page_frames (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_character,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_frame_byte,
   output logic            rsp_frame_first,
   output logic            rsp_frame_end,
   output logic            rsp_run_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_data
);
   import tlop_pkg::*;

   logic          ctype_ff;
   logic          queue_full;
   logic          pop;
   tlop_slot_type push;
   tlop_slot_type head;

   // controller type register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctype_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         ctype_ff <= csr_data;
      end
   end

   tlop_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_character (req_character),
      .queue_full    (queue_full),
      .ctype         (ctype_ff),
      .req_stall     (req_stall),
      .push          (push)
   );

   tlop_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   tlop_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_frame_first (rsp_frame_first),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_run_last    (rsp_run_last)
   );

   // a byte that opens a transaction never closes it
   a_first_not_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_first |-> !rsp_frame_end)
      else $error("frame byte flagged both first and end");

   // opening bytes are the command control byte or the data control byte
   a_first_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_first |->
         (rsp_frame_byte == CMD_CTRL) || (rsp_frame_byte == DATA_CTRL))
      else $error("unexpected byte opens a transaction");

   // the data control byte is always followed by columns of the same character
   a_data_ctrl_not_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_first && (rsp_frame_byte == DATA_CTRL) |-> !rsp_run_last)
      else $error("character run ends on the data control byte");

endmodule
`default_nettype wire

### src/tlop_front.sv
// front end: tracks line state and turns each character into a descriptor
`default_nettype none
module tlop_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [7:0]             req_character,
   input  wire logic                   queue_full,
   input  wire logic                   ctype,
   output logic                        req_stall,
   output tlop_pkg::tlop_slot_type     push
);
   import tlop_pkg::*;

   localparam logic [5:0] LAST_POS   = 6'(LINE_CHARS - 1);
   localparam logic [3:0] PAGE_LIMIT = 4'(LINE_COUNT);

   logic [2:0] line_page_ff, line_page_in;
   logic [5:0] char_pos_ff, char_pos_in;
   logic [7:0] col_count_ff, col_count_in;

   logic       accept;
   logic       first_char;
   logic       last_char;
   logic       has_glyph;
   logic [7:0] col_after;
   logic [3:0] page_inc;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // classify the character against the line state
   assign first_char = (char_pos_ff == 6'd0);
   assign last_char  = (char_pos_ff >= LAST_POS);
   assign has_glyph  = (col_count_ff < GLYPH_LIMIT);
   assign col_after  = has_glyph ? (col_count_ff + GLYPH_STEP) : col_count_ff;
   assign page_inc   = {1'b0, line_page_ff} + 4'd1;

   // descriptor for the back end, dropped when it yields no transfer
   always_comb begin
      push.desc.open       = first_char;
      push.desc.page       = line_page_ff;
      push.desc.ctype      = ctype;
      push.desc.glyph      = has_glyph;
      push.desc.glyph_cols = glyph_of(req_character);
      push.desc.pad        = last_char;
      push.desc.pad_start  = col_after;
      push.valid           = accept && (first_char || has_glyph || last_char);
   end

   // line state update
   always_comb begin
      line_page_in = line_page_ff;
      char_pos_in  = char_pos_ff;
      col_count_in = col_count_ff;
      if (accept) begin
         if (last_char) begin
            char_pos_in  = 6'd0;
            col_count_in = 8'd0;
            line_page_in = (page_inc >= PAGE_LIMIT) ? 3'd0 : page_inc[2:0];
         end else begin
            char_pos_in  = char_pos_ff + 6'd1;
            col_count_in = col_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_page_ff <= 3'd0;
         char_pos_ff  <= 6'd0;
         col_count_ff <= 8'd0;
      end else begin
         line_page_ff <= line_page_in;
         char_pos_ff  <= char_pos_in;
         col_count_ff <= col_count_in;
      end
   end

endmodule
`default_nettype wire

### src/tlop_queue.sv
// short descriptor queue between front and back end
`default_nettype none
module tlop_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  tlop_pkg::tlop_slot_type     push,
   input  wire logic                   pop,
   output logic                        full,
   output tlop_pkg::tlop_slot_type     head
);
   import tlop_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   tlop_desc_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.desc  = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.desc;
      end
   end

endmodule
`default_nettype wire

### src/tlop_back.sv
// back end: sequences the bytes of each descriptor into the output register
`default_nettype none
module tlop_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  tlop_pkg::tlop_slot_type     head,
   output logic                        pop,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_frame_byte,
   output logic                        rsp_frame_first,
   output logic                        rsp_frame_end,
   output logic                        rsp_run_last
);
   import tlop_pkg::*;

   localparam logic [1:0] PH_OPEN  = 2'd0;
   localparam logic [1:0] PH_GLYPH = 2'd1;
   localparam logic [1:0] PH_PAD   = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [2:0] step_ff, step_in;
   logic [7:0] col_ff, col_in;
   logic       start_ff, start_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff;
   logic       first_ff, end_ff, last_ff;

   tlop_desc_type d;
   logic [1:0] cur_phase;
   logic [2:0] cur_step;
   logic [7:0] cur_col;
   logic       advance;
   logic       done;
   logic [7:0] out_byte;
   logic       out_first;
   logic       out_end;
   logic [1:0] nxt_phase;
   logic [2:0] nxt_step;
   logic [7:0] nxt_col;

   assign d       = head.desc;
   assign advance = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop     = advance && done;

   // position within the current descriptor
   always_comb begin
      if (start_ff) begin
         cur_phase = d.open ? PH_OPEN : (d.glyph ? PH_GLYPH : PH_PAD);
         cur_step  = 3'd0;
         cur_col   = d.pad_start;
      end else begin
         cur_phase = phase_ff;
         cur_step  = step_ff;
         cur_col   = col_ff;
      end
   end

   // byte selection and next position
   always_comb begin
      out_byte  = CMD_CTRL;
      out_first = 1'b0;
      out_end   = 1'b0;
      done      = 1'b0;
      nxt_phase = cur_phase;
      nxt_step  = cur_step + 3'd1;
      nxt_col   = cur_col;
      unique case (cur_phase)
         PH_OPEN: begin
            unique case (cur_step)
               3'd1: begin
                  out_byte = {CMD_PAGE_HI, d.page};
                  out_end  = 1'b1;
               end
               3'd3: begin
                  out_byte = d.ctype ? OFFSET_ALT : OFFSET_STD;
                  out_end  = 1'b1;
               end
               3'd5: begin
                  out_byte = CMD_COL_HI;
                  out_end  = 1'b1;
               end
               3'd6: begin
                  out_byte  = DATA_CTRL;
                  out_first = 1'b1;
               end
               default: begin
                  out_byte  = CMD_CTRL;
                  out_first = 1'b1;
               end
            endcase
            if (cur_step == 3'd6) begin
               nxt_step = 3'd0;
               if (d.glyph) begin
                  nxt_phase = PH_GLYPH;
               end else if (d.pad) begin
                  nxt_phase = PH_PAD;
                  nxt_col   = d.pad_start;
               end else begin
                  done = 1'b1;
               end
            end
         end
         PH_GLYPH: begin
            unique case (cur_step)
               3'd0:    out_byte = d.glyph_cols[39:32];
               3'd1:    out_byte = d.glyph_cols[31:24];
               3'd2:    out_byte = d.glyph_cols[23:16];
               3'd3:    out_byte = d.glyph_cols[15:8];
               3'd4:    out_byte = d.glyph_cols[7:0];
               default: out_byte = CMD_CTRL;
            endcase
            if (cur_step >= 3'd5) begin
               nxt_step = 3'd0;
               if (d.pad) begin
                  nxt_phase = PH_PAD;
                  nxt_col   = d.pad_start;
               end else begin
                  done = 1'b1;
               end
            end
         end
         default: begin
            out_byte = CMD_CTRL;
            out_end  = (cur_col == LAST_COL);
            done     = (cur_col >= LAST_COL);
            nxt_col  = cur_col + 8'd1;
         end
      endcase
   end

   // sequencer registers
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      col_in   = col_ff;
      start_in = start_ff;
      if (advance) begin
         phase_in = nxt_phase;
         step_in  = nxt_step;
         col_in   = nxt_col;
         start_in = done;
      end
   end

   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPEN;
         step_ff      <= 3'd0;
         col_ff       <= 8'd0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         col_ff       <= col_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff  <= out_byte;
         first_ff <= out_first;
         end_ff   <= out_end;
         last_ff  <= done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_byte  = byte_ff;
   assign rsp_frame_first = first_ff;
   assign rsp_frame_end   = end_ff;
   assign rsp_run_last    = last_ff;

endmodule
`default_nettype wire
